// ===== rtl/assert_macros.svh =====
// assertion helpers for the hash block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a consequence on the same edge
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/sha_pkg.sv =====
package sha_pkg;
	localparam int QueueDepth = 4;
	localparam int QueueAw = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	typedef logic [31:0] word_t;

	function automatic word_t init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef enum logic [5:0] {
		ST_FILL  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_OUT   = 6'b100000
	} back_state_t;
endpackage

// ===== rtl/sha_ifs.sv =====
interface sha_byte_if;
	logic                    valid;
	logic                    ready;
	sha_pkg::byte_item_t     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface sha_digest_if;
	logic                    valid;
	logic                    ready;
	sha_pkg::digest_item_t   payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/sha256_stream_hash.sv =====
// sha-256 over a byte stream
// din: one message byte per transaction with an end_of_message flag; a message
//   has at least one byte
// dout: eight digest words, word_index 0 first, last_word on the eighth
// a small queue takes bytes while the core compresses, so the source stalls
//   only when the queue fills
// the core takes one byte a cycle while it fills a block; each full 64-byte
//   block then runs 64 rounds, one per cycle, plus one add
// after the final byte, padding and one or two compressions run before the
//   first digest word shows
// the digest words wait while dout.ready is low; nothing is lost
// reset loads the standard initial hash and empties the queue
// the next message may start right after the final byte
`include "assert_macros.svh"
module sha256_stream_hash (
	input  logic         clk,
	input  logic         arst_n,
	sha_byte_if.sink     din,
	sha_digest_if.source dout
);
	import sha_pkg::*;

	logic       q_full, q_empty, take;
	byte_item_t head;

	assign din.ready = !q_full;

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(din.valid), .push_item(din.payload), .full(q_full),
		.pop(take), .pop_item(head), .empty(q_empty)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.item_valid(!q_empty), .item(head), .item_take(take),
		.dout(dout)
	);

	`ASSERT_IMPLY(a_take_nonempty, clk, arst_n, take, !q_empty, "pop from empty queue")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, dout.valid && !dout.ready, dout.valid, "digest dropped while stalled")
	`ASSERT_IMPLY(a_no_take_out, clk, arst_n, dout.valid, !take, "byte taken during output")
endmodule

// ===== rtl/sha_queue.sv =====
module sha_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sha_pkg::byte_item_t push_item,
	output logic               full,
	input  logic               pop,
	output sha_pkg::byte_item_t pop_item,
	output logic               empty
);
	import sha_pkg::*;

	byte_item_t           mem_q [QueueDepth];
	logic [QueueAw-1:0]   wr_q, rd_q;
	logic [QueueAw:0]     cnt_q;

	assign full = cnt_q == QueueAw'(0) + (QueueAw+1)'(QueueDepth);
	assign empty = cnt_q == '0;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueueAw+1)'(push && !full) - (QueueAw+1)'(pop && !empty);
		end
	end
endmodule

// ===== rtl/sha_core.sv =====
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  sha_pkg::byte_item_t item,
	output logic                item_take,
	sha_digest_if.source        dout
);
	import sha_pkg::*;

	back_state_t  state_q;
	word_t        blk_q [16];
	word_t        hash_q [8];
	word_t        v_q [8];
	logic [5:0]   fill_q;
	logic [60:0]  total_q;
	logic [5:0]   rnd_q;
	logic         final_q;   // padding byte 0x80 already written
	logic         second_q;  // length block still to do after this compression
	logic [2:0]   oidx_q;

	word_t s0, s1, w_new, w_cur, t1, t2, bs0, bs1, ch, maj;
	word_t        eom_word;
	logic [3:0]   wi;
	logic [1:0]   bi;
	logic [63:0]  bits;

	assign item_take = state_q == ST_FILL && item_valid;
	assign wi = fill_q[5:2];
	assign bi = fill_q[1:0];
	assign bits = {total_q, 3'b000};

	// final byte, then 0x80 where it fits, zeros below
	assign eom_word = (blk_q[wi] & ~(32'hffffffff >> (bi*8)))
		| ({item.data_byte, 8'h80, 16'h0000} >> (bi*8));

	// message schedule kept in the block buffer as a 16-word window
	always_comb begin
		s0 = {blk_q[1][6:0], blk_q[1][31:7]} ^ {blk_q[1][17:0], blk_q[1][31:18]}
			^ (blk_q[1] >> 3);
		s1 = {blk_q[14][16:0], blk_q[14][31:17]} ^ {blk_q[14][18:0], blk_q[14][31:19]}
			^ (blk_q[14] >> 10);
		w_new = blk_q[0] + s0 + blk_q[9] + s1;
		w_cur = blk_q[0];
		bs1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + bs1 + ch + RoundK[rnd_q] + w_cur;
		bs0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = bs0 + maj;
	end

	assign dout.valid = state_q == ST_OUT;
	assign dout.payload.digest_word = hash_q[oidx_q];
	assign dout.payload.word_index = oidx_q;
	assign dout.payload.last_word = oidx_q == 3'd7;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_FILL: if (item_valid) begin
				if (item.end_of_message && fill_q != 6'd63)
					blk_q[wi] <= eom_word;
				else
					blk_q[wi][(3-bi)*8 +: 8] <= item.data_byte;
				if (fill_q == 6'd63 || (item.end_of_message && bi != 2'd3 && wi == 4'd15))
					for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
			end
			ST_PAD: begin
				// fill from fill_q up with 0x80 then zeros, one word a step
				if (bi == 2'd0) blk_q[wi] <= final_q ? 32'h0 : 32'h80000000;
				else if (!final_q) blk_q[wi] <= blk_q[wi] & ~(32'hffffffff >> (bi*8));
				else blk_q[wi] <= blk_q[wi] & ~(32'hffffffff >> (bi*8));
				if (fill_q[5:2] == 4'd15 || (!second_q && fill_q[5:2] == 4'd13))
					for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
			end
			ST_LEN: begin
				blk_q[14] <= bits[63:32];
				blk_q[15] <= bits[31:0];
				for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
				blk_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			total_q <= '0;
			rnd_q <= '0;
			final_q <= 1'b0;
			second_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
		end else begin
			case (state_q)
				ST_FILL: if (item_valid) begin
					fill_q <= fill_q + 6'd1;
					total_q <= total_q + 61'd1;
					rnd_q <= '0;
					if (fill_q == 6'd63) begin
						final_q <= 1'b0;
						second_q <= item.end_of_message;
						state_q <= ST_ROUND;
					end else if (item.end_of_message) begin
						// 0x80 already placed when it fits in this word
						final_q <= bi != 2'd3;
						second_q <= fill_q >= 6'd55;
						fill_q <= (bi == 2'd3) ? fill_q + 6'd1 : {fill_q[5:2] + 4'd1, 2'b00};
						if (bi == 2'd3) state_q <= ST_PAD;
						else if (fill_q[5:2] == 4'd15) state_q <= ST_ROUND;
						else if (fill_q[5:2] == 4'd13) state_q <= ST_LEN;
						else state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					// final_q marks that 0x80 was already written
					final_q <= 1'b1;
					fill_q <= {fill_q[5:2] + 4'd1, 2'b00};
					if (fill_q[5:2] == 4'd15) begin
						state_q <= ST_ROUND;
					end else if (!second_q && fill_q[5:2] == 4'd13) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					second_q <= 1'b0;
					final_q <= 1'b1;
					fill_q <= 6'd1; // marks the length block
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					if (second_q) begin
						// padding continues into a fresh block
						fill_q <= '0;
						second_q <= 1'b0;
						state_q <= ST_PAD;
					end else if (final_q && fill_q == 6'd1) begin
						oidx_q <= '0;
						state_q <= ST_OUT;
					end else begin
						fill_q <= '0;
						final_q <= 1'b0;
						state_q <= ST_FILL;
					end
				end
				ST_OUT: if (dout.ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
						fill_q <= '0;
						total_q <= '0;
						final_q <= 1'b0;
						state_q <= ST_FILL;
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end
endmodule
